### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; fbpa_ctrl.sv is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FBPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBPA_ASSERT(label, clk, rst, prop, msg)
`define FBPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/fbpa_pkg.sv
`default_nettype none
package fbpa_pkg;

   localparam int unsigned MAX_BLOCKS_PER_CHUNK = 64;
   localparam int unsigned MAX_CHUNKS           = 16;

   localparam int unsigned OFFSET_W = $clog2(MAX_BLOCKS_PER_CHUNK);
   localparam int unsigned CHUNK_W  = $clog2(MAX_CHUNKS);
   localparam int unsigned HANDLE_W = OFFSET_W + CHUNK_W;
   localparam int unsigned BPC_W    = 7;
   localparam int unsigned LIMIT_W  = 5;
   localparam int unsigned COUNT_W  = 32;

   localparam logic [BPC_W-1:0]   BPC_RESET   = BPC_W'(MAX_BLOCKS_PER_CHUNK);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_CHUNKS);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SRC_STACK = 2'd0,
      SRC_CHUNK = 2'd1,
      SRC_NEW   = 2'd2,
      SRC_NONE  = 2'd3
   } source_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_OOM      = 2'd1,
      STS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic {
      CSR_BLOCKS_PER_CHUNK = 1'b0,
      CSR_CHUNK_LIMIT      = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;   // item taken, link read issued
      logic execute;   // update pool state, produce result
   } ctl_cmd_type;

endpackage
`default_nettype wire

### hw/rtl/fbpa_csr.sv
`default_nettype none
module fbpa_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire fbpa_pkg::csr_index_type          csr_index,
   input  wire logic [fbpa_pkg::BPC_W-1:0]       csr_wdata,
   output logic      [fbpa_pkg::BPC_W-1:0]       bpc_eff,
   output logic      [fbpa_pkg::LIMIT_W-1:0]     limit_eff
);

   logic [fbpa_pkg::BPC_W-1:0]   bpc_ff, bpc_in;
   logic [fbpa_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   always_comb begin
      bpc_in   = bpc_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            fbpa_pkg::CSR_BLOCKS_PER_CHUNK: bpc_in   = csr_wdata;
            fbpa_pkg::CSR_CHUNK_LIMIT:      limit_in = csr_wdata[fbpa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff   <= fbpa_pkg::BPC_RESET;
         limit_ff <= fbpa_pkg::LIMIT_RESET;
      end else begin
         bpc_ff   <= bpc_in;
         limit_ff <= limit_in;
      end
   end

   // saturate into the legal ranges
   always_comb begin
      priority if (bpc_ff == '0)
         bpc_eff = fbpa_pkg::BPC_W'(1);
      else if (bpc_ff > fbpa_pkg::BPC_RESET)
         bpc_eff = fbpa_pkg::BPC_RESET;
      else
         bpc_eff = bpc_ff;

      priority if (limit_ff == '0)
         limit_eff = fbpa_pkg::LIMIT_W'(1);
      else if (limit_ff > fbpa_pkg::LIMIT_RESET)
         limit_eff = fbpa_pkg::LIMIT_RESET;
      else
         limit_eff = limit_ff;
   end

endmodule
`default_nettype wire

### hw/rtl/fbpa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module fbpa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output fbpa_pkg::ctl_cmd_type      cmd,
   output logic                       rsp_strobe
);

   fbpa_pkg::state_type state_ff, state_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbpa_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      busy          = 1'b0;
      cmd           = '0;
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = fbpa_pkg::ST_EXEC;
            end
         end
         fbpa_pkg::ST_EXEC: begin
            busy          = 1'b1;
            cmd.execute   = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = fbpa_pkg::ST_IDLE;
         end
         default: state_in = fbpa_pkg::ST_IDLE;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;

   `FBPA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept did not raise busy")
   `FBPA_ASSERT(a_exec_rsp, clock, reset, busy |=> (rsp_strobe && !busy), "exec gave no result")
   `FBPA_ASSERT(a_rsp_from_exec, clock, reset, rsp_strobe |-> $past(cmd.execute), "stray result strobe")

endmodule
`default_nettype wire

### hw/rtl/fbpa_datapath.sv
`default_nettype none
module fbpa_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fbpa_pkg::ctl_cmd_type              cmd,
   input  wire logic                               req_op,
   input  wire logic [fbpa_pkg::HANDLE_W-1:0]      req_block_index,
   input  wire logic [fbpa_pkg::BPC_W-1:0]         bpc,
   input  wire logic [fbpa_pkg::LIMIT_W-1:0]       limit,
   output logic      [fbpa_pkg::HANDLE_W-1:0]      granted_index,
   output logic      [1:0]                         source,
   output logic      [1:0]                         status,
   output logic      [fbpa_pkg::COUNT_W-1:0]       alloc_count,
   output logic      [fbpa_pkg::COUNT_W-1:0]       stack_hit_count,
   output logic      [fbpa_pkg::COUNT_W-1:0]       chunk_hit_count,
   output logic      [fbpa_pkg::LIMIT_W-1:0]       chunks_open
);

   localparam int unsigned HW    = fbpa_pkg::HANDLE_W;
   localparam int unsigned OW    = fbpa_pkg::OFFSET_W;
   localparam int unsigned CW    = fbpa_pkg::CHUNK_W;
   localparam int unsigned BW    = fbpa_pkg::BPC_W;
   localparam int unsigned LW    = fbpa_pkg::LIMIT_W;
   localparam int unsigned NW    = fbpa_pkg::COUNT_W;
   localparam int unsigned DEPTH = 1 << HW;

   // link memory entry: {more, link}
   logic [HW:0] link_mem [DEPTH];
   logic [HW:0] rd_ff;
   logic        wr_en;

   logic          op_ff;
   logic [HW-1:0] idx_ff;

   logic [HW-1:0] head_ff, head_in;
   logic          nonempty_ff, nonempty_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [BW-1:0] used_ff, used_in;
   logic [NW-1:0] allocs_ff, allocs_in;
   logic [NW-1:0] shits_ff, shits_in;
   logic [NW-1:0] chits_ff, chits_in;

   logic [HW-1:0]        granted_ff, granted_in;
   fbpa_pkg::source_type source_ff, source_in;
   fbpa_pkg::status_type status_ff, status_in;

   logic [LW-1:0] cur_plus1;
   logic [BW-1:0] bpc_m1;
   logic [BW-1:0] chunk_off;
   logic          bad_free;

   assign cur_plus1 = LW'(cur_ff) + LW'(1);
   assign bpc_m1    = bpc - BW'(1);
   assign chunk_off = bpc_m1 - used_ff;
   assign bad_free  = (idx_ff[HW-1:OW] > cur_ff) || (BW'(idx_ff[OW-1:0]) >= bpc);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         idx_ff <= req_block_index;
         rd_ff  <= link_mem[head_ff];
      end
      if (wr_en)
         link_mem[idx_ff] <= {nonempty_ff, head_ff};
   end

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      cur_in      = cur_ff;
      used_in     = used_ff;
      allocs_in   = allocs_ff;
      shits_in    = shits_ff;
      chits_in    = chits_ff;
      granted_in  = granted_ff;
      source_in   = source_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      if (cmd.execute) begin
         granted_in = '0;
         source_in  = fbpa_pkg::SRC_NONE;
         status_in  = fbpa_pkg::STS_OK;
         if (op_ff == fbpa_pkg::OP_ALLOC) begin
            allocs_in = allocs_ff + NW'(1);
            priority if (nonempty_ff) begin
               shits_in    = shits_ff + NW'(1);
               granted_in  = head_ff;
               source_in   = fbpa_pkg::SRC_STACK;
               head_in     = rd_ff[HW-1:0];
               nonempty_in = rd_ff[HW];
            end else if (used_ff < bpc) begin
               chits_in   = chits_ff + NW'(1);
               granted_in = {cur_ff, chunk_off[OW-1:0]};
               used_in    = used_ff + BW'(1);
               source_in  = fbpa_pkg::SRC_CHUNK;
            end else if (cur_plus1 < limit) begin
               cur_in     = cur_plus1[CW-1:0];
               used_in    = BW'(1);
               granted_in = {cur_plus1[CW-1:0], bpc_m1[OW-1:0]};
               source_in  = fbpa_pkg::SRC_NEW;
            end else begin
               status_in = fbpa_pkg::STS_OOM;
            end
         end else begin
            if (bad_free) begin
               status_in = fbpa_pkg::STS_BAD_FREE;
            end else begin
               wr_en       = 1'b1;
               head_in     = idx_ff;
               nonempty_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         cur_ff      <= '0;
         used_ff     <= '0;
         allocs_ff   <= '0;
         shits_ff    <= '0;
         chits_ff    <= '0;
      end else begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         cur_ff      <= cur_in;
         used_ff     <= used_in;
         allocs_ff   <= allocs_in;
         shits_ff    <= shits_in;
         chits_ff    <= chits_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      source_ff  <= source_in;
      status_ff  <= status_in;
   end

   assign granted_index   = granted_ff;
   assign source          = source_ff;
   assign status          = status_ff;
   assign alloc_count     = allocs_ff;
   assign stack_hit_count = shits_ff;
   assign chunk_hit_count = chits_ff;
   assign chunks_open     = cur_plus1;

endmodule
`default_nettype wire

### hw/rtl/fixed_block_pool_allocator_unit.sv
// Channel   Ports                                   Handshake
// request   req_op, req_block_index                 start & !busy
// result    rsp_granted_index .. rsp_chunks_open    rsp_strobe, one cycle
// config    csr_we, csr_index, csr_wdata            csr_we, no wait
//
// An item is taken on the accept edge, which reads the link memory at the stack
// head; in the EXEC state the pool is updated and the result registered.
// The result strobe is high in the cycle after that; the next item may be
// accepted in that same cycle. Synchronous reset empties the free stack and
// opens chunk 0; the link memory is not cleared. The receiver cannot stall.
`default_nettype none
module fixed_block_pool_allocator_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_op,
   input  wire logic [fbpa_pkg::HANDLE_W-1:0]   req_block_index,
   output logic                                 rsp_strobe,
   output logic      [fbpa_pkg::HANDLE_W-1:0]   rsp_granted_index,
   output logic      [1:0]                      rsp_source,
   output logic      [1:0]                      rsp_status,
   output logic      [fbpa_pkg::COUNT_W-1:0]    rsp_alloc_count,
   output logic      [fbpa_pkg::COUNT_W-1:0]    rsp_stack_hit_count,
   output logic      [fbpa_pkg::COUNT_W-1:0]    rsp_chunk_hit_count,
   output logic      [fbpa_pkg::LIMIT_W-1:0]    rsp_chunks_open,
   input  wire logic                            csr_we,
   input  wire logic                            csr_index,
   input  wire logic [fbpa_pkg::BPC_W-1:0]      csr_wdata
);

   fbpa_pkg::ctl_cmd_type             cmd;
   logic [fbpa_pkg::BPC_W-1:0]        bpc_eff;
   logic [fbpa_pkg::LIMIT_W-1:0]      limit_eff;

   fbpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (fbpa_pkg::csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .bpc_eff   (bpc_eff),
      .limit_eff (limit_eff)
   );

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   fbpa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_block_index (req_block_index),
      .bpc             (bpc_eff),
      .limit           (limit_eff),
      .granted_index   (rsp_granted_index),
      .source          (rsp_source),
      .status          (rsp_status),
      .alloc_count     (rsp_alloc_count),
      .stack_hit_count (rsp_stack_hit_count),
      .chunk_hit_count (rsp_chunk_hit_count),
      .chunks_open     (rsp_chunks_open)
   );

endmodule
`default_nettype wire
